// ----- src/coo_spmv_accumulate_core_assert.svh -----
// Assertion macros shared by the accumulate core RTL.
`ifndef COO_SPMV_ACCUMULATE_CORE_ASSERT_SVH
`define COO_SPMV_ACCUMULATE_CORE_ASSERT_SVH

// same-cycle implication
`define CSPMV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CSPMV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/cspmv_pkg.sv -----
// Shared constants, types and helpers for the COO sparse matrix-vector core.
package cspmv_pkg;

	localparam int DIM    = 1024;
	localparam int ADDR_W = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int IDX_W  = 10;
	localparam int VAL_W  = 32;
	localparam int ACC_W  = 64;
	localparam int PROD_W = 2 * VAL_W;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_MAC  = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic              add;
		logic [ADDR_W-1:0] wr_addr;
	} acc_cmd_t;

	function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
		return ADDR_W'(idx);
	endfunction

endpackage

// ----- src/cspmv_acc_bank.sv -----
// Row accumulator memory with post-reset clear sweep and read-modify-write adder.
`include "coo_spmv_accumulate_core_assert.svh"

module cspmv_acc_bank (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cspmv_pkg::acc_cmd_t                  cmd,
	input  logic signed [cspmv_pkg::PROD_W-1:0]  prod,
	output logic [cspmv_pkg::ACC_W-1:0]          rd_data,
	output logic                                 busy
);
	import cspmv_pkg::*;

	logic [ACC_W-1:0]  mem [DIM];
	logic [ACC_W-1:0]  rd_q;
	logic [ADDR_W-1:0] clr_q;
	logic              busy_q;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ACC_W-1:0]  wr_data;

	always_comb begin
		if (busy_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = cmd.wr_en;
			wr_addr = cmd.wr_addr;
			wr_data = cmd.add ? (rd_q + ACC_W'(prod)) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == ADDR_W'(DIM - 1))
				busy_q <= 1'b0;
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rd_q <= mem[cmd.rd_addr];
	end

	assign rd_data = rd_q;
	assign busy    = busy_q;

	`CSPMV_ASSERT_IMP(a_clear_exclusive, busy_q, !cmd.wr_en && !cmd.rd_en,
		"accumulator access during clear sweep")

endmodule

// ----- src/coo_spmv_accumulate_core.sv -----
// Top level of the COO sparse matrix-vector multiply-accumulate core.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid, in_stall, req_type, row_index,       | in
//          | col_index, value                               |
//  out     | out_valid, out_stall, row_sum                  | out
//
// Load beat: vector write. Nonzero beat: vector/accumulator read, registered
// 32x32 multiply, then accumulator write-back. Read beat: accumulator read,
// then output load, delayed only while an untaken result is held.
// After reset the accumulator memory is swept to zero, all DIM (1024) entries,
// with in_stall high. Other items are taken while a result waits on out_stall.
`include "coo_spmv_accumulate_core_assert.svh"

module coo_spmv_accumulate_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          req_type,
	input  logic [cspmv_pkg::IDX_W-1:0]         row_index,
	input  logic [cspmv_pkg::IDX_W-1:0]         col_index,
	input  logic signed [cspmv_pkg::VAL_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [cspmv_pkg::ACC_W-1:0]  row_sum
);
	import cspmv_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ACC  = 4'b0100,
		ST_RD   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic signed [VAL_W-1:0]  vec_mem [DIM];
	logic signed [VAL_W-1:0]  vec_rd_q;
	logic signed [VAL_W-1:0]  val_s1;
	logic [ADDR_W-1:0]        row_s1;
	logic                     rd_ok_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     out_valid_q;
	logic [ACC_W-1:0]         row_sum_q;

	logic             accept, row_ok, col_ok;
	logic             is_load, is_mac, is_read;
	logic             mac_go, vec_we, slot_free, acc_busy;
	logic [ACC_W-1:0] acc_rd;
	acc_cmd_t         acc_cmd;

	always_comb begin
		is_load = 1'b0;
		is_mac  = 1'b0;
		is_read = 1'b0;
		unique case (req_type)
			REQ_LOAD: is_load = 1'b1;
			REQ_MAC:  is_mac  = 1'b1;
			REQ_READ: is_read = 1'b1;
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE) || acc_busy;
	assign accept    = in_valid && !in_stall;
	assign row_ok    = int'(row_index) < DIM;
	assign col_ok    = int'(col_index) < DIM;
	assign mac_go    = is_mac && row_ok && col_ok;
	assign vec_we    = accept && is_load && col_ok;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		acc_cmd.rd_en   = accept && (mac_go || (is_read && row_ok));
		acc_cmd.rd_addr = to_addr(row_index);
		acc_cmd.wr_en   = (state_q == ST_ACC) ||
			((state_q == ST_RD) && slot_free && rd_ok_s1);
		acc_cmd.add     = (state_q == ST_ACC);
		acc_cmd.wr_addr = row_s1;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && mac_go)
					state_d = ST_MUL;
				else if (accept && is_read)
					state_d = ST_RD;
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: state_d = ST_IDLE;
			ST_RD: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_RD) && slot_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_s1   <= value;
			row_s1   <= to_addr(row_index);
			rd_ok_s1 <= row_ok;
		end
		if (vec_we)
			vec_mem[to_addr(col_index)] <= value;
		if (accept && mac_go)
			vec_rd_q <= vec_mem[to_addr(col_index)];
		if (state_q == ST_MUL)
			prod_s2 <= PROD_W'(val_s1) * PROD_W'(vec_rd_q);
		if ((state_q == ST_RD) && slot_free)
			row_sum_q <= rd_ok_s1 ? acc_rd : '0;
	end

	cspmv_acc_bank u_acc_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (acc_cmd),
		.prod    (prod_s2),
		.rd_data (acc_rd),
		.busy    (acc_busy)
	);

	assign out_valid = out_valid_q;
	assign row_sum   = row_sum_q;

	`CSPMV_ASSERT_IMP(a_mac_writeback, accept && mac_go,
		##2 (acc_cmd.wr_en && acc_cmd.add), "nonzero beat missed its write-back")
	`CSPMV_ASSERT_NXT(a_read_result, (state_q == ST_RD) && slot_free,
		out_valid_q && (state_q == ST_IDLE), "read beat did not load the output")
	`CSPMV_ASSERT_IMP(a_clear_holds_input, acc_busy, in_stall,
		"input taken during clear sweep")

endmodule

// ----- dv/coo_spmv_accumulate_core_tb.sv -----
// Testbench for coo_spmv_accumulate_core: predicted row sums checked beat by beat.
`timescale 1ns / 100ps

module coo_spmv_accumulate_core_tb;
	import cspmv_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int STALL_LIMIT = 5000;

	class spmv_shadow;
		bit signed [VAL_W-1:0] vec_shadow[DIM];
		bit [ACC_W-1:0] acc_shadow[DIM];
		logic [ACC_W-1:0] pending_sums[$];
		int errors;

		function void take_request(logic [1:0] kind, logic [IDX_W-1:0] row,
				logic [IDX_W-1:0] col, logic [VAL_W-1:0] val);
			logic signed [ACC_W-1:0] lhs, rhs;
			lhs = ACC_W'($signed(val));
			rhs = ACC_W'(vec_shadow[col]);
			case (kind)
				REQ_LOAD: vec_shadow[col] = val;
				REQ_MAC: acc_shadow[row] += lhs * rhs;
				REQ_READ: begin
					pending_sums.push_back(acc_shadow[row]);
					acc_shadow[row] = '0;
				end
				default: ;
			endcase
		endfunction

		function void match_row_sum(logic [ACC_W-1:0] got);
			logic [ACC_W-1:0] want;
			if (pending_sums.size() == 0) begin
				$display("%0t: unexpected row_sum beat, expected none, got %h", $time, got);
				errors++;
				return;
			end
			want = pending_sums.pop_front();
			if (got !== want) begin
				$display("%0t: row_sum mismatch, expected %h, got %h", $time, want, got);
				errors++;
			end
		endfunction

		function int pending();
			return pending_sums.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] req_type;
	logic [IDX_W-1:0] row_index;
	logic [IDX_W-1:0] col_index;
	logic signed [VAL_W-1:0] value;
	logic out_valid;
	logic out_stall;
	logic signed [ACC_W-1:0] row_sum;

	spmv_shadow shadow = new();
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int quiet_cycles;
	bit col_loaded[DIM];
	int loaded_cols[$];

	coo_spmv_accumulate_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.row_index(row_index),
		.col_index(col_index),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.row_sum(row_sum)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// receiver: random stalls, or a long hold-off counted here
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else
				out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.match_row_sum(row_sum);
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, no beat for %0d cycles", $time, quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the beat
	task automatic send_item(input logic [1:0] kind, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		row_index <= row;
		col_index <= col;
		value <= val;
		do
			@(posedge clk);
		while (in_stall);
		shadow.take_request(kind, row, col, val);
		if (kind == REQ_LOAD && !col_loaded[col]) begin
			col_loaded[col] = 1'b1;
			loaded_cols.push_back(int'(col));
		end
		@(negedge clk);
	endtask

	// nonzeros only ever hit loaded vector entries
	task automatic random_burst(input int n, input int read_pct);
		int pick;
		logic [1:0] kind;
		logic [IDX_W-1:0] row, col;
		logic [VAL_W-1:0] val;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 4)
				kind = REQ_NONE;
			else if (pick < 20 || loaded_cols.size() == 0)
				kind = REQ_LOAD;
			else if (pick < 100 - read_pct)
				kind = REQ_MAC;
			else
				kind = REQ_READ;
			row = ($urandom_range(99) < 80) ? IDX_W'($urandom_range(15)) :
				IDX_W'($urandom_range(1023));
			col = IDX_W'($urandom_range(1023));
			if (kind == REQ_LOAD && $urandom_range(1))
				col = IDX_W'($urandom_range(31));
			if (kind == REQ_MAC)
				col = IDX_W'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
			case ($urandom_range(7))
				0: val = 32'h7fff_ffff;
				1: val = 32'h8000_0000;
				2: val = $urandom_range(15);
				3: val = -$urandom_range(15);
				default: val = $urandom;
			endcase
			send_item(kind, row, col, val);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (shadow.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		row_index = '0;
		col_index = '0;
		value = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, back-to-back same row, wrap, load-to-use, unused code
		send_item(REQ_LOAD, 10'h000, 10'h000, 32'h7fff_ffff);
		send_item(REQ_LOAD, 10'h3ff, 10'h3ff, 32'h8000_0000);
		send_item(REQ_LOAD, 10'h155, 10'h001, 32'hffff_ffff);
		send_item(REQ_LOAD, 10'h3ff, 10'h2aa, 32'h5555_5555);
		send_item(REQ_LOAD, 10'h000, 10'h155, 32'haaaa_aaaa);
		send_item(REQ_MAC, 10'h000, 10'h000, 32'h7fff_ffff);
		send_item(REQ_MAC, 10'h000, 10'h3ff, 32'h8000_0000);
		send_item(REQ_MAC, 10'h000, 10'h001, 32'h0000_0001);
		send_item(REQ_READ, 10'h000, 10'h3ff, 32'hffff_ffff);
		send_item(REQ_READ, 10'h000, 10'h000, 32'h0000_0000);
		send_item(REQ_MAC, 10'h3ff, 10'h3ff, 32'h8000_0000);
		send_item(REQ_MAC, 10'h3ff, 10'h3ff, 32'h8000_0000);
		send_item(REQ_MAC, 10'h3ff, 10'h3ff, 32'h8000_0000);
		send_item(REQ_MAC, 10'h2aa, 10'h2aa, 32'h5555_5555);
		send_item(REQ_MAC, 10'h155, 10'h155, 32'haaaa_aaaa);
		send_item(REQ_READ, 10'h3ff, 10'h3ff, 32'hffff_ffff);
		send_item(REQ_LOAD, 10'h2aa, 10'h000, 32'h0000_0002);
		send_item(REQ_MAC, 10'h007, 10'h000, 32'hffff_fffd);
		send_item(REQ_NONE, 10'h007, 10'h000, 32'hffff_ffff);
		send_item(REQ_READ, 10'h007, 10'h000, 32'h0000_0000);
		send_item(REQ_READ, 10'h2aa, 10'h155, 32'h1234_5678);
		send_item(REQ_READ, 10'h155, 10'h2aa, 32'h8765_4321);
		send_item(REQ_READ, 10'h200, 10'h3ff, 32'h0000_0000);
		send_item(REQ_MAC, 10'h000, 10'h001, 32'h0000_0000);
		send_item(REQ_READ, 10'h000, 10'h000, 32'h0000_0000);

		send_idle_pct = 28;
		recv_stall_pct = 68;
		random_burst(360, 15);

		// long receiver hold-off while the sender keeps offering
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 400;
		random_burst(120, 30);
		drain_results();

		send_idle_pct = 68;
		recv_stall_pct = 28;
		random_burst(300, 15);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_burst(300, 15);

		drain_results();
		repeat (20) @(negedge clk);
		if (shadow.errors == 0 && shadow.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/cspmv_pkg.sv
src/cspmv_acc_bank.sv
src/coo_spmv_accumulate_core.sv
dv/coo_spmv_accumulate_core_tb.sv
